// ===== rtl/core/assert_macros.svh =====
// shared assertion macros, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dts_pkg.sv =====
`default_nettype none

package dts_pkg;

  localparam int CoordW   = 16;
  localparam int SizeW    = 15;
  localparam int MonW     = 8;
  localparam int IdxW     = 8;
  localparam int Cen2W    = 18;   // doubled center 2*x + w
  localparam int DiffW    = 19;   // difference of two doubled centers
  localparam int DistW    = 18;   // primary / secondary distance magnitude
  localparam int SpanW    = 17;   // span end x + w
  localparam int OvlW     = 15;   // beam overlap

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int MaxTargetsDefault = 256;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCurX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCurY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCurW     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCurH     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCurMon   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCurIdx   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMoveDir  = 3'd6;

  // move directions
  localparam logic [1:0] DirLeft  = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirUp    = 2'd2;
  localparam logic [1:0] DirDown  = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] cand_x;
    logic signed [CoordW-1:0] cand_y;
    logic [SizeW-1:0]         cand_w;
    logic [SizeW-1:0]         cand_h;
    logic [MonW-1:0]          cand_monitor;
    logic                     cand_last;
  } cand_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] target_index;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dts_stream_if.sv =====
`default_nettype none

interface dts_cand_if;
  logic           valid;
  logic           ready;
  dts_pkg::cand_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dts_res_if;
  logic          valid;
  logic          ready;
  dts_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/directional_target_select.sv =====
// result: the beat marked last is taken into the input stage, then its result is loaded into the output register
// throughput: one candidate per cycle; a full output register holding a result only
//   stalls the input while a further last beat waits behind it and res.ready is low
// reset: rst_ni clears the valid flags, the running best's valid flag and the position counter at
//   once, not the payload registers; no clearing pass, the block takes beats right after reset
`default_nettype none

module directional_target_select #(
  parameter int MAX_TARGETS = dts_pkg::MaxTargetsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dts_pkg::CfgDataW-1:0] cfg_wdata_i,
  dts_cand_if.sink                          cand,
  dts_res_if.source                         res
);

  localparam int PosW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CntW = $clog2(MAX_TARGETS + 1);
  localparam int CmpW = (PosW > dts_pkg::IdxW) ? PosW : dts_pkg::IdxW;

  // configuration
  logic signed [dts_pkg::CoordW-1:0] cur_x_q, cur_y_q;
  logic [dts_pkg::SizeW-1:0]         cur_w_q, cur_h_q;
  logic [dts_pkg::MonW-1:0]          cur_mon_q;
  logic [dts_pkg::IdxW-1:0]          cur_idx_q;
  logic [1:0]                        dir_q;

  // input stage
  logic            s1_valid_q;
  dts_pkg::cand_t  s1_data_q;
  logic [PosW-1:0] s1_pos_q;
  logic            s1_range_q;
  logic            s1_cur_q;
  logic [CntW-1:0] cnt_q;

  // running best
  logic                       best_valid_q;
  logic                       seen_q;
  logic [PosW-1:0]            best_pos_q;
  logic [dts_pkg::OvlW-1:0]   best_ovl_q;
  logic [dts_pkg::DistW-1:0]  best_prim_q;
  logic                       best_other_q;
  logic [dts_pkg::DistW-1:0]  best_sec_q;

  // output register
  logic          out_valid_q;
  dts_pkg::res_t out_data_q;

  logic s1_adv, in_fire, s2_fire, in_range, in_cur;

  assign s1_adv  = !(s1_valid_q && s1_data_q.cand_last && out_valid_q && !res.ready);
  assign in_fire = cand.valid && s1_adv;
  assign s2_fire = s1_valid_q && s1_adv;

  assign cand.ready  = s1_adv;
  assign res.valid   = out_valid_q;
  assign res.payload = out_data_q;

  assign in_range = cnt_q < CntW'(MAX_TARGETS);
  assign in_cur   = CmpW'(cnt_q[PosW-1:0]) == CmpW'(cur_idx_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      cur_w_q   <= '0;
      cur_h_q   <= '0;
      cur_mon_q <= '0;
      cur_idx_q <= '0;
      dir_q     <= dts_pkg::DirLeft;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dts_pkg::RegCurX:    cur_x_q   <= cfg_wdata_i;
        dts_pkg::RegCurY:    cur_y_q   <= cfg_wdata_i;
        dts_pkg::RegCurW:    cur_w_q   <= cfg_wdata_i[dts_pkg::SizeW-1:0];
        dts_pkg::RegCurH:    cur_h_q   <= cfg_wdata_i[dts_pkg::SizeW-1:0];
        dts_pkg::RegCurMon:  cur_mon_q <= cfg_wdata_i[dts_pkg::MonW-1:0];
        dts_pkg::RegCurIdx:  cur_idx_q <= cfg_wdata_i[dts_pkg::IdxW-1:0];
        dts_pkg::RegMoveDir: dir_q     <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 2 math
  logic signed [dts_pkg::Cen2W-1:0] fcx2, fcy2, ccx2, ccy2;
  logic signed [dts_pkg::DiffW-1:0] dx, dy, prim, sec_raw, sec_abs;
  logic signed [dts_pkg::SpanW-1:0] a0, a1, b0, b1, hi, lo;
  logic signed [dts_pkg::SpanW:0]   span_diff;
  logic [dts_pkg::OvlW-1:0]         ovl;
  logic [dts_pkg::DistW-1:0]        prim_u, sec_u;
  logic                             horiz, eligible, other, better, take;
  logic                             best_valid_d, seen_d;
  logic [PosW-1:0]                  best_pos_d;
  logic [CmpW-1:0]                  pos_ext;

  assign fcx2 = $signed({cur_x_q[dts_pkg::CoordW-1], cur_x_q, 1'b0})
              + $signed({3'b000, cur_w_q});
  assign fcy2 = $signed({cur_y_q[dts_pkg::CoordW-1], cur_y_q, 1'b0})
              + $signed({3'b000, cur_h_q});
  assign ccx2 = $signed({s1_data_q.cand_x[dts_pkg::CoordW-1], s1_data_q.cand_x, 1'b0})
              + $signed({3'b000, s1_data_q.cand_w});
  assign ccy2 = $signed({s1_data_q.cand_y[dts_pkg::CoordW-1], s1_data_q.cand_y, 1'b0})
              + $signed({3'b000, s1_data_q.cand_h});

  assign dx = $signed({ccx2[dts_pkg::Cen2W-1], ccx2}) - $signed({fcx2[dts_pkg::Cen2W-1], fcx2});
  assign dy = $signed({ccy2[dts_pkg::Cen2W-1], ccy2}) - $signed({fcy2[dts_pkg::Cen2W-1], fcy2});

  assign horiz = (dir_q == dts_pkg::DirLeft) || (dir_q == dts_pkg::DirRight);

  always_comb begin
    unique case (dir_q)
      dts_pkg::DirLeft:  prim = -dx;
      dts_pkg::DirRight: prim = dx;
      dts_pkg::DirUp:    prim = -dy;
      dts_pkg::DirDown:  prim = dy;
      default:           prim = dy;
    endcase
  end

  assign eligible = !prim[dts_pkg::DiffW-1] && (prim != '0);
  assign prim_u   = prim[dts_pkg::DistW-1:0];

  assign sec_raw = horiz ? dy : dx;
  assign sec_abs = sec_raw[dts_pkg::DiffW-1] ? -sec_raw : sec_raw;
  assign sec_u   = sec_abs[dts_pkg::DistW-1:0];

  // beam spans on the axis across the move
  always_comb begin
    if (horiz) begin
      a0 = $signed({cur_y_q[dts_pkg::CoordW-1], cur_y_q});
      a1 = $signed({cur_y_q[dts_pkg::CoordW-1], cur_y_q}) + $signed({2'b00, cur_h_q});
      b0 = $signed({s1_data_q.cand_y[dts_pkg::CoordW-1], s1_data_q.cand_y});
      b1 = $signed({s1_data_q.cand_y[dts_pkg::CoordW-1], s1_data_q.cand_y})
         + $signed({2'b00, s1_data_q.cand_h});
    end else begin
      a0 = $signed({cur_x_q[dts_pkg::CoordW-1], cur_x_q});
      a1 = $signed({cur_x_q[dts_pkg::CoordW-1], cur_x_q}) + $signed({2'b00, cur_w_q});
      b0 = $signed({s1_data_q.cand_x[dts_pkg::CoordW-1], s1_data_q.cand_x});
      b1 = $signed({s1_data_q.cand_x[dts_pkg::CoordW-1], s1_data_q.cand_x})
         + $signed({2'b00, s1_data_q.cand_w});
    end
  end

  assign hi        = (a1 < b1) ? a1 : b1;
  assign lo        = (a0 > b0) ? a0 : b0;
  assign span_diff = $signed({hi[dts_pkg::SpanW-1], hi}) - $signed({lo[dts_pkg::SpanW-1], lo});
  assign ovl       = (hi > lo) ? span_diff[dts_pkg::OvlW-1:0] : '0;

  assign other = s1_data_q.cand_monitor != cur_mon_q;

  // lexicographic rank against the running best, ties keep the earlier one
  always_comb begin
    priority if (!best_valid_q) begin
      better = 1'b1;
    end else if ((ovl != '0) != (best_ovl_q != '0)) begin
      better = (ovl != '0);
    end else if (prim_u != best_prim_q) begin
      better = prim_u < best_prim_q;
    end else if (other != best_other_q) begin
      better = !other;
    end else if (ovl != best_ovl_q) begin
      better = ovl > best_ovl_q;
    end else begin
      better = sec_u < best_sec_q;
    end
  end

  assign take         = s2_fire && s1_range_q && !s1_cur_q && eligible && better;
  assign best_valid_d = best_valid_q || take;
  assign seen_d       = seen_q || (s1_range_q && s1_cur_q);
  assign best_pos_d   = take ? s1_pos_q : best_pos_q;
  assign pos_ext      = CmpW'(best_pos_d);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_range_q   <= 1'b0;
      s1_cur_q     <= 1'b0;
      cnt_q        <= '0;
      best_valid_q <= 1'b0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= cand.valid;
      end
      if (in_fire) begin
        s1_range_q <= in_range;
        s1_cur_q   <= in_cur;
        if (cand.payload.cand_last) begin
          cnt_q <= '0;
        end else if (in_range) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (s2_fire) begin
        if (s1_data_q.cand_last) begin
          best_valid_q <= 1'b0;
          seen_q       <= 1'b0;
        end else begin
          best_valid_q <= best_valid_d;
          seen_q       <= seen_d;
        end
      end
      if (s2_fire && s1_data_q.cand_last) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= cand.payload;
      s1_pos_q  <= cnt_q[PosW-1:0];
    end
    if (take) begin
      best_pos_q   <= s1_pos_q;
      best_ovl_q   <= ovl;
      best_prim_q  <= prim_u;
      best_other_q <= other;
      best_sec_q   <= sec_u;
    end
    if (s2_fire && s1_data_q.cand_last) begin
      out_data_q.found        <= best_valid_d && seen_d;
      out_data_q.target_index <= (best_valid_d && seen_d) ? pos_ext[dts_pkg::IdxW-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dts_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module dts_chk (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     in_last_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic                     out_found_i,
  input wire logic [dts_pkg::IdxW-1:0] out_index_i
);

  // a miss always reports index zero
  `DTS_ASSERT_IMP(a_miss_index_zero, out_valid_i && !out_found_i, out_index_i == '0, "miss with nonzero index")

  // a stalled result beat holds
  `DTS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_found_i) && $stable(out_index_i), "stalled result changed")

  // a fresh result follows an accepted last beat
  `DTS_ASSERT_IMP(a_out_after_last, out_valid_i && !$past(out_valid_i), $past(in_valid_i && in_ready_i && in_last_i, 2), "result without last beat")

  // with the output register empty the input never stalls
  `DTS_ASSERT_IMP(a_ready_when_empty, !out_valid_i, in_ready_i, "input stalled with empty output")

endmodule

bind directional_target_select dts_chk u_dts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cand.valid),
  .in_ready_i  (cand.ready),
  .in_last_i   (cand.payload.cand_last),
  .out_valid_i (res.valid),
  .out_ready_i (res.ready),
  .out_found_i (res.payload.found),
  .out_index_i (res.payload.target_index)
);

`default_nettype wire
